// File: hw/rtl/uvs_pkg.sv
// Shared types, constants and the CORDIC angle table for the UV-sphere vertex generator.
`default_nettype none
package uvs_pkg;

  localparam int IDX_W = 16;
  localparam int CNT_W = 8;
  localparam int Q15_W = 16;
  localparam int DIV_W = CNT_W + 1;

  localparam logic [31:0] GAIN_Q32 = 32'h9B74_EDA8;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] k1;
    logic [IDX_W-1:0] k2;
  } tri_tag_t;

  typedef struct packed {
    logic     neg_a;
    logic     neg_b;
    tri_tag_t quad;
  } cor_tag_t;

  // atan(2^-k) as a fraction of a full turn, scaled by 2^32.
  function automatic logic [31:0] cordic_atan(input int k);
    logic [31:0] a;
    case (k)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051E;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2F;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2FA;
      15:      a = 32'h0000_517D;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A30;
      19:      a = 32'h0000_0518;
      20:      a = 32'h0000_028C;
      21:      a = 32'h0000_0146;
      22:      a = 32'h0000_00A3;
      23:      a = 32'h0000_0051;
      24:      a = 32'h0000_0029;
      25:      a = 32'h0000_0014;
      26:      a = 32'h0000_000A;
      27:      a = 32'h0000_0005;
      28:      a = 32'h0000_0003;
      29:      a = 32'h0000_0001;
      30:      a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/uv_sphere_vertex_generator_unit.sv
// Top level of the UV-sphere vertex generator: config registers, divider and CORDIC chains.
//
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_stack_index, in_sector_index
// out_      output     out_valid/out_stall  out_pos_x/y/z, out_tri_valid, out_tri_a0..b2
// config    input      APB (psel, penable)  sector_count at 0x0, stack_count at 0x4
//
// One transfer is accepted per cycle while in_stall is low. The chain holds, in order, one
// divider cell per quotient bit of the angle divider, one CORDIC cell per rotation, the
// product register and the output register.
// Reset (synchronous, rst_n low) clears all valid bits and loads the counts 36 and 18.
// A stall on a valid output freezes the whole chain, and in_stall follows it in the same cycle.
`default_nettype none
module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
  parameter int COORD_BITS    = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CNT_W-1:0]   in_stack_index,
  input  wire logic [CNT_W-1:0]   in_sector_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [Q15_W-1:0]        out_pos_x,
  output logic [Q15_W-1:0]        out_pos_y,
  output logic [Q15_W-1:0]        out_pos_z,
  output logic                    out_tri_valid,
  output logic [IDX_W-1:0]        out_tri_a0,
  output logic [IDX_W-1:0]        out_tri_a1,
  output logic [IDX_W-1:0]        out_tri_a2,
  output logic [IDX_W-1:0]        out_tri_b0,
  output logic [IDX_W-1:0]        out_tri_b1,
  output logic [IDX_W-1:0]        out_tri_b2,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Angle and fixed-point geometry.
  localparam int A   = ANGLE_BITS;
  localparam int F   = COORD_BITS - 1;
  localparam int NW  = A + 9;            // divider numerator width
  localparam int NS  = CORDIC_STAGES;
  localparam int XW  = COORD_BITS + 2;   // CORDIC x/y width with headroom
  localparam int ZW  = 34;               // residual angle, turns scaled by 2^32
  localparam int PW  = 2 * XW;           // product width
  localparam int SW  = PW + 2;           // width used while scaling to Q1.15

  localparam logic [A-1:0]  QUARTER  = A'(1) << (A - 2);
  localparam logic [32:0]   GAIN_RND = 33'(GAIN_Q32) + (33'd1 << (31 - F));
  localparam logic signed [XW-1:0] X0 = signed'(XW'(GAIN_RND >> (32 - F)));
  localparam logic signed [PW:0]   MRND = signed'((PW + 1)'(1) << (F - 1));
  localparam int SH_DN = (F > 15) ? F - 15 : 0;
  localparam int SH_UP = (F > 15) ? 0 : 15 - F;
  localparam logic signed [SW-1:0] QRND =
    (F > 15) ? signed'(SW'(1) << ((F > 15) ? F - 16 : 0)) : signed'(SW'(0));
  localparam logic signed [SW-1:0] QMAX = signed'(SW'(32767));
  localparam logic signed [SW-1:0] QMIN = -signed'(SW'(32768));

  localparam logic [CNT_W-1:0] SEC_MIN = CNT_W'(3);
  localparam logic [CNT_W-1:0] STK_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0] SEC_RST = CNT_W'(36);
  localparam logic [CNT_W-1:0] STK_RST = CNT_W'(18);
  localparam logic             REG_SECTOR = 1'b0;
  localparam logic             REG_STACK  = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the chain is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] sector_count_r, stack_count_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= SEC_RST;
      stack_count_r  <= STK_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SECTOR) begin
        sector_count_r <= pwdata[CNT_W-1:0];
      end else begin
        stack_count_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_STACK) begin
      prdata = {{(32-CNT_W){1'b0}}, stack_count_r};
    end else begin
      prdata = {{(32-CNT_W){1'b0}}, sector_count_r};
    end
  end

  // Counts below their legal minimum behave as the minimum.
  logic [CNT_W-1:0] sec_eff, stk_eff;
  assign sec_eff = (sector_count_r < SEC_MIN) ? SEC_MIN : sector_count_r;
  assign stk_eff = (stack_count_r < STK_MIN) ? STK_MIN : stack_count_r;

  // ---------------------------------------------------------------------------
  // Global advance. The chain moves unless a finished vertex is held at the output.
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic adv;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------------------
  // Entry: triangle indices, and the numerators and divisors of the two angles.
  // The longitude code is round(j*2^A/sectors) = (j*2^(A+1) + sectors) / (2*sectors),
  // and the latitude offset is (i*2^A + stacks) / (2*stacks).
  // ---------------------------------------------------------------------------
  logic [DIV_W-1:0]  sec_p1;
  logic [17:0]       k1_full;
  logic [IDX_W-1:0]  k1, k2;
  logic              quad_ok;
  tri_tag_t          tag_in;
  logic [DIV_W-1:0]  d_lon, d_lat;

  always_comb begin
    sec_p1  = {1'b0, sec_eff} + DIV_W'(1);
    k1_full = 18'(in_stack_index) * 18'(sec_p1) + 18'(in_sector_index);
    k1      = k1_full[IDX_W-1:0];
    k2      = IDX_W'(k1_full + 18'(sec_p1));
    quad_ok = (in_stack_index < stk_eff) && (in_sector_index < sec_eff);
    tag_in.valid = quad_ok;
    tag_in.k1    = quad_ok ? k1 : '0;
    tag_in.k2    = quad_ok ? k2 : '0;
    d_lon = {sec_eff, 1'b0};
    d_lat = {stk_eff, 1'b0};
  end

  // Divider chain: one quotient bit per cell.
  logic             dv      [0:NW];
  logic [DIV_W-1:0] lon_rem [0:NW];
  logic [NW-1:0]    lon_nq  [0:NW];
  logic [DIV_W-1:0] lat_rem [0:NW];
  logic [NW-1:0]    lat_nq  [0:NW];
  tri_tag_t         dtag    [0:NW];

  assign dv[0]      = in_valid;
  assign lon_rem[0] = '0;
  assign lat_rem[0] = '0;
  assign lon_nq[0]  = (NW'(in_sector_index) << (A + 1)) | NW'(sec_eff);
  assign lat_nq[0]  = (NW'(in_stack_index) << A) | NW'(stk_eff);
  assign dtag[0]    = tag_in;

  for (genvar s = 0; s < NW; s++) begin : g_div
    uvs_div_cell #(.NW(NW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .v_in       (dv[s]),
      .d_lon      (d_lon),
      .d_lat      (d_lat),
      .lon_rem_in (lon_rem[s]),
      .lon_nq_in  (lon_nq[s]),
      .lat_rem_in (lat_rem[s]),
      .lat_nq_in  (lat_nq[s]),
      .tag_in     (dtag[s]),
      .v_r        (dv[s+1]),
      .lon_rem_r  (lon_rem[s+1]),
      .lon_nq_r   (lon_nq[s+1]),
      .lat_rem_r  (lat_rem[s+1]),
      .lat_nq_r   (lat_nq[s+1]),
      .tag_r      (dtag[s+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Angle codes to 32-bit turns, with the half-turn fold for the left half plane.
  // ---------------------------------------------------------------------------
  logic [A-1:0]          lon_code, lat_code;
  logic [31:0]           turn_a, turn_b, sum_a, sum_b;
  logic                  neg_a, neg_b;
  logic signed [31:0]    fold_a, fold_b;
  cor_tag_t              ctag0;

  always_comb begin
    lon_code = lon_nq[NW][A-1:0];
    lat_code = QUARTER - lat_nq[NW][A-1:0];
    turn_a   = 32'(lat_code) << (32 - A);
    turn_b   = 32'(lon_code) << (32 - A);
    sum_a    = turn_a + 32'h4000_0000;
    sum_b    = turn_b + 32'h4000_0000;
    neg_a    = sum_a[31];
    neg_b    = sum_b[31];
    fold_a   = signed'(turn_a ^ {neg_a, 31'b0});
    fold_b   = signed'(turn_b ^ {neg_b, 31'b0});
    ctag0.neg_a = neg_a;
    ctag0.neg_b = neg_b;
    ctag0.quad  = dtag[NW];
  end

  // CORDIC chain: lane a is the latitude, lane b the longitude.
  logic                 cv  [0:NS];
  logic signed [XW-1:0] xa  [0:NS];
  logic signed [XW-1:0] ya  [0:NS];
  logic signed [ZW-1:0] za  [0:NS];
  logic signed [XW-1:0] xb  [0:NS];
  logic signed [XW-1:0] yb  [0:NS];
  logic signed [ZW-1:0] zb  [0:NS];
  cor_tag_t             ctag[0:NS];

  assign cv[0]   = dv[NW];
  assign xa[0]   = X0;
  assign ya[0]   = '0;
  assign za[0]   = ZW'(fold_a);
  assign xb[0]   = X0;
  assign yb[0]   = '0;
  assign zb[0]   = ZW'(fold_b);
  assign ctag[0] = ctag0;

  for (genvar k = 0; k < NS; k++) begin : g_cordic
    uvs_cordic_cell #(.K(k), .XW(XW), .ZW(ZW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .v_in   (cv[k]),
      .xa_in  (xa[k]),
      .ya_in  (ya[k]),
      .za_in  (za[k]),
      .xb_in  (xb[k]),
      .yb_in  (yb[k]),
      .zb_in  (zb[k]),
      .tag_in (ctag[k]),
      .v_r    (cv[k+1]),
      .xa_r   (xa[k+1]),
      .ya_r   (ya[k+1]),
      .za_r   (za[k+1]),
      .xb_r   (xb[k+1]),
      .yb_r   (yb[k+1]),
      .zb_r   (zb[k+1]),
      .tag_r  (ctag[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Undo the fold, then form cos(lat)cos(lon) and cos(lat)sin(lon).
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0] clat, slat, clon, slon;
  logic                 pv_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [XW-1:0] pz_r;
  tri_tag_t             ptag_r;

  always_comb begin
    clat = ctag[NS].neg_a ? -xa[NS] : xa[NS];
    slat = ctag[NS].neg_a ? -ya[NS] : ya[NS];
    clon = ctag[NS].neg_b ? -xb[NS] : xb[NS];
    slon = ctag[NS].neg_b ? -yb[NS] : yb[NS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (adv) begin
      pv_r <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= clat * clon;
      py_r   <= clat * slon;
      pz_r   <= slat;
      ptag_r <= ctag[NS].quad;
    end
  end

  // Rescale to Q1.15 with round half up, then saturate.
  function automatic logic [Q15_W-1:0] to_q15(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = ((v + QRND) >>> SH_DN) <<< SH_UP;
    if (r > QMAX) begin
      return 16'h7FFF;
    end else if (r < QMIN) begin
      return 16'h8000;
    end else begin
      return r[Q15_W-1:0];
    end
  endfunction

  // Round a product half up back to F fraction bits.
  function automatic logic signed [SW-1:0] mul_round(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = ((PW + 1)'(p) + MRND) >>> F;
    return SW'(t);
  endfunction

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic [Q15_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  tri_tag_t         otag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= to_q15(mul_round(px_r));
      pos_y_r <= to_q15(mul_round(py_r));
      pos_z_r <= to_q15(SW'(pz_r));
      otag_r  <= ptag_r;
    end
  end

  // An invalid quad carries zero in every triangle index, including the +1 ones.
  assign out_valid     = out_valid_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_pos_z     = pos_z_r;
  assign out_tri_valid = otag_r.valid;
  assign out_tri_a0    = otag_r.k1;
  assign out_tri_a1    = otag_r.k2;
  assign out_tri_a2    = otag_r.valid ? otag_r.k1 + IDX_W'(1) : '0;
  assign out_tri_b0    = otag_r.valid ? otag_r.k1 + IDX_W'(1) : '0;
  assign out_tri_b1    = otag_r.k2;
  assign out_tri_b2    = otag_r.valid ? otag_r.k2 + IDX_W'(1) : '0;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_invalid_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tri_valid |-> out_tri_a0 == '0 && out_tri_a1 == '0 && out_tri_b2 == '0)
    else $error("invalid quad carries nonzero indices");

  a_row_stride: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tri_valid |-> out_tri_a1 - out_tri_a0 == IDX_W'(sec_p1))
    else $error("row stride differs from sector count plus one");

  a_shared_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tri_valid |-> out_tri_a2 == out_tri_b0 && out_tri_b2 == out_tri_b1 + 1'b1)
    else $error("quad triangles do not share their edge");

endmodule
`default_nettype wire

// File: hw/rtl/uvs_div_cell.sv
// One restoring-division step for the longitude and latitude lanes, with the triangle tag.
`default_nettype none
module uvs_div_cell import uvs_pkg::*; #(
  parameter int NW = 25
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             v_in,
  input  wire logic [DIV_W-1:0] d_lon,
  input  wire logic [DIV_W-1:0] d_lat,
  input  wire logic [DIV_W-1:0] lon_rem_in,
  input  wire logic [NW-1:0]    lon_nq_in,
  input  wire logic [DIV_W-1:0] lat_rem_in,
  input  wire logic [NW-1:0]    lat_nq_in,
  input  wire tri_tag_t         tag_in,
  output logic                  v_r,
  output logic [DIV_W-1:0]      lon_rem_r,
  output logic [NW-1:0]         lon_nq_r,
  output logic [DIV_W-1:0]      lat_rem_r,
  output logic [NW-1:0]         lat_nq_r,
  output tri_tag_t              tag_r
);

  logic [DIV_W:0]   lon_try, lat_try;
  logic             lon_ge, lat_ge;
  logic [DIV_W-1:0] lon_rem_nxt, lat_rem_nxt;

  // Bring down the next numerator bit; the quotient bit fills the freed LSB.
  always_comb begin
    lon_try     = {lon_rem_in, lon_nq_in[NW-1]};
    lat_try     = {lat_rem_in, lat_nq_in[NW-1]};
    lon_ge      = lon_try >= {1'b0, d_lon};
    lat_ge      = lat_try >= {1'b0, d_lat};
    lon_rem_nxt = lon_ge ? DIV_W'(lon_try - {1'b0, d_lon}) : lon_try[DIV_W-1:0];
    lat_rem_nxt = lat_ge ? DIV_W'(lat_try - {1'b0, d_lat}) : lat_try[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_rem_r <= lon_rem_nxt;
      lat_rem_r <= lat_rem_nxt;
      lon_nq_r  <= {lon_nq_in[NW-2:0], lon_ge};
      lat_nq_r  <= {lat_nq_in[NW-2:0], lat_ge};
      tag_r     <= tag_in;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/uvs_cordic_cell.sv
// One CORDIC rotation step for the latitude and longitude lanes, with the carried tag.
`default_nettype none
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int K  = 0,
  parameter int XW = 18,
  parameter int ZW = 34
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_in,
  input  wire logic signed [XW-1:0] xa_in,
  input  wire logic signed [XW-1:0] ya_in,
  input  wire logic signed [ZW-1:0] za_in,
  input  wire logic signed [XW-1:0] xb_in,
  input  wire logic signed [XW-1:0] yb_in,
  input  wire logic signed [ZW-1:0] zb_in,
  input  wire cor_tag_t             tag_in,
  output logic                      v_r,
  output logic signed [XW-1:0]      xa_r,
  output logic signed [XW-1:0]      ya_r,
  output logic signed [ZW-1:0]      za_r,
  output logic signed [XW-1:0]      xb_r,
  output logic signed [XW-1:0]      yb_r,
  output logic signed [ZW-1:0]      zb_r,
  output cor_tag_t                  tag_r
);

  localparam logic signed [ZW-1:0] ATAN = signed'(ZW'(cordic_atan(K)));

  logic signed [XW-1:0] xa_nxt, ya_nxt, xb_nxt, yb_nxt;
  logic signed [ZW-1:0] za_nxt, zb_nxt;

  always_comb begin
    if (!za_in[ZW-1]) begin
      xa_nxt = xa_in - (ya_in >>> K);
      ya_nxt = ya_in + (xa_in >>> K);
      za_nxt = za_in - ATAN;
    end else begin
      xa_nxt = xa_in + (ya_in >>> K);
      ya_nxt = ya_in - (xa_in >>> K);
      za_nxt = za_in + ATAN;
    end
    if (!zb_in[ZW-1]) begin
      xb_nxt = xb_in - (yb_in >>> K);
      yb_nxt = yb_in + (xb_in >>> K);
      zb_nxt = zb_in - ATAN;
    end else begin
      xb_nxt = xb_in + (yb_in >>> K);
      yb_nxt = yb_in - (xb_in >>> K);
      zb_nxt = zb_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa_r  <= xa_nxt;
      ya_r  <= ya_nxt;
      za_r  <= za_nxt;
      xb_r  <= xb_nxt;
      yb_r  <= yb_nxt;
      zb_r  <= zb_nxt;
      tag_r <= tag_in;
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_uv_sphere_vertex_generator_unit.sv
// Self-checking testbench for the UV-sphere vertex generator: directed and random requests.
`default_nettype none
module tb_uv_sphere_vertex_generator_unit;

  // Register indexes of the configuration port.
  localparam int REG_SECTORS = 0;
  localparam int REG_STACKS  = 1;

  // The settle time after draining is longer than the latency through the whole pipeline.
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ROT_STAGES    = 16;

  // Each CORDIC stage rotates by atan(2^-k), given as a fraction of a turn scaled by 2^32.
  localparam logic [31:0] ATAN_TURN [0:ROT_STAGES-1] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  // One result: vertex position and the two triangles of its quad.
  typedef struct {
    logic [15:0] x, y, z;
    logic        tv;
    logic [15:0] a0, a1, a2, b0, b1, b2;
  } vertex_t;

  typedef enum logic [1:0] {ROW_VERTEX, ROW_COUNTS} row_kind_t;

  // A directed row either writes both counts or sends one request. Where has_tri is set,
  // the triangle fields are typed in and replace the predicted ones.
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  p0, p1;
    logic        has_tri;
    logic        tv;
    logic [15:0] a0, a1, a2, b0, b1, b2;
  } row_t;

  localparam int NUM_ROWS = 21;
  row_t rows [0:NUM_ROWS-1] = '{
    // Counts after reset are 36 sectors and 18 stacks.
    '{ROW_VERTEX, 8'd0,   8'd0,   1, 1, 16'd0,   16'd37,  16'd1,   16'd1,   16'd37,  16'd38},
    '{ROW_VERTEX, 8'd0,   8'd35,  1, 1, 16'd35,  16'd72,  16'd36,  16'd36,  16'd72,  16'd73},
    '{ROW_VERTEX, 8'd17,  8'd35,  1, 1, 16'd664, 16'd701, 16'd665, 16'd665, 16'd701, 16'd702},
    '{ROW_VERTEX, 8'd18,  8'd0,   1, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd0,   8'd36,  1, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd255, 8'd255, 1, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd9,   8'd9,   0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd9,   8'd18,  0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd170, 8'd85,  0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd85,  8'd170, 0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    // Zero counts are clamped to three sectors and two stacks.
    '{ROW_COUNTS, 8'd0,   8'd0,   0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd1,   8'd2,   1, 1, 16'd6,   16'd10,  16'd7,   16'd7,   16'd10,  16'd11},
    '{ROW_VERTEX, 8'd2,   8'd0,   1, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd1,   8'd1,   0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_COUNTS, 8'd2,   8'd1,   0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd1,   8'd3,   0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    // Largest counts give the highest triangle indices.
    '{ROW_COUNTS, 8'd255, 8'd255, 0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd254, 8'd254, 1, 1, 16'd65278, 16'd65534, 16'd65279, 16'd65279,
      16'd65534, 16'd65535},
    '{ROW_VERTEX, 8'd255, 8'd254, 1, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd128, 8'd64,  0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0},
    '{ROW_VERTEX, 8'd0,   8'd127, 0, 0, 16'd0,   16'd0,   16'd0,   16'd0,   16'd0,   16'd0}
  };

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] in_stack_index, in_sector_index;
  logic [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_tri_valid;
  logic [15:0] out_tri_a0, out_tri_a1, out_tri_a2, out_tri_b0, out_tri_b1, out_tri_b2;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  uv_sphere_vertex_generator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_stack_index(in_stack_index), .in_sector_index(in_sector_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_tri_valid(out_tri_valid),
    .out_tri_a0(out_tri_a0), .out_tri_a1(out_tri_a1), .out_tri_a2(out_tri_a2),
    .out_tri_b0(out_tri_b0), .out_tri_b1(out_tri_b1), .out_tri_b2(out_tri_b2),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copies of the two count registers.
  logic [7:0] sectors_q = 8'd36;
  logic [7:0] stacks_q  = 8'd18;

  vertex_t pending_vertices [$];
  int mismatches  = 0;
  int cycles      = 0;
  int send_idle   = 0;
  int recv_idle   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rotation-mode CORDIC on a 32-bit turn code, 15 fraction bits.
  function automatic void rotate(input logic [31:0] turn, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic [31:0] t, probe;
    logic flip;
    x = (64'h9B74_EDA8 + 64'h1_0000) >> 17;
    y = 0;
    probe = turn + 32'h4000_0000;
    flip = probe[31];
    t = flip ? turn - 32'h8000_0000 : turn;
    z = $signed(t);
    for (int k = 0; k < ROT_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURN[k]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURN[k]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint product_q15(input longint a, input longint b);
    return (a * b + 64'sd16384) >>> 15;
  endfunction

  function automatic logic [15:0] saturate_q15(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Expected vertex and quad for one request under the current counts.
  function automatic vertex_t sphere_vertex(input logic [7:0] si, input logic [7:0] sj);
    vertex_t v;
    longint sec, stk, lon, lat, k1, k2, clat, slat, clon, slon;
    sec = (sectors_q < 3) ? 3 : sectors_q;
    stk = (stacks_q < 2) ? 2 : stacks_q;
    lon = (longint'(sj) * 131072 + sec) / (2 * sec);
    lat = 16384 - (longint'(si) * 65536 + stk) / (2 * stk);
    rotate({lat[15:0], 16'h0}, clat, slat);
    rotate({lon[15:0], 16'h0}, clon, slon);
    v.x  = saturate_q15(product_q15(clat, clon));
    v.y  = saturate_q15(product_q15(clat, slon));
    v.z  = saturate_q15(slat);
    v.tv = (si < stk) && (sj < sec);
    k1 = longint'(si) * (sec + 1) + sj;
    k2 = k1 + sec + 1;
    v.a0 = v.tv ? k1[15:0] : 16'h0;
    v.a1 = v.tv ? k2[15:0] : 16'h0;
    v.a2 = v.tv ? k1[15:0] + 16'd1 : 16'h0;
    v.b0 = v.a2;
    v.b1 = v.a1;
    v.b2 = v.tv ? k2[15:0] + 16'd1 : 16'h0;
    return v;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    mismatches++;
  endtask

  // Present one request and wait for its transfer. The valid stays high afterwards so
  // that back-to-back requests never lower and raise it in the same step.
  task automatic send_request(input logic [7:0] si, input logic [7:0] sj, input logic has_tri,
                              input vertex_t typed);
    vertex_t v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_stack_index  <= si;
    in_sector_index <= sj;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = sphere_vertex(si, sj);
    if (has_tri) begin
      v.tv = typed.tv; v.a0 = typed.a0; v.a1 = typed.a1; v.a2 = typed.a2;
      v.b0 = typed.b0; v.b1 = typed.b1; v.b2 = typed.b2;
    end
    pending_vertices.insert(pending_vertices.size(), v);
    @(negedge clk);
  endtask

  // Drop valid, wait until every expected vertex is out and the pipeline has settled.
  task automatic drain;
    in_valid <= 1'b0;
    wait (pending_vertices.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The bus goes idle after each write, so writes never overlap.
  task automatic write_count(input int idx, input logic [7:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(idx * 4);
    pwdata  <= {24'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_SECTORS) sectors_q = value;
    else stacks_q = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_count(input int lo);
    int r;
    r = $urandom_range(7);
    if (r == 0) return 8'(lo);
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(lo - 1));
    return 8'($urandom_range(40, lo));
  endfunction

  // Mostly indices on the sphere grid, including the closing row and column, plus some
  // noise over the whole field range.
  function automatic logic [7:0] random_index(input logic [7:0] count);
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(count));
  endfunction

  // The receiver stalls at random; the decision changes only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Compare each transferred vertex against the oldest expectation.
  always @(posedge clk) begin
    vertex_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected transfer", 16'd1, 16'd0);
      end else begin
        w = pending_vertices.pop_front();
        if (out_pos_x !== w.x) report_mismatch("pos_x", out_pos_x, w.x);
        if (out_pos_y !== w.y) report_mismatch("pos_y", out_pos_y, w.y);
        if (out_pos_z !== w.z) report_mismatch("pos_z", out_pos_z, w.z);
        if (out_tri_valid !== w.tv) report_mismatch("tri_valid", 16'(out_tri_valid), 16'(w.tv));
        if (out_tri_a0 !== w.a0) report_mismatch("tri_a0", out_tri_a0, w.a0);
        if (out_tri_a1 !== w.a1) report_mismatch("tri_a1", out_tri_a1, w.a1);
        if (out_tri_a2 !== w.a2) report_mismatch("tri_a2", out_tri_a2, w.a2);
        if (out_tri_b0 !== w.b0) report_mismatch("tri_b0", out_tri_b0, w.b0);
        if (out_tri_b1 !== w.b1) report_mismatch("tri_b1", out_tri_b1, w.b1);
        if (out_tri_b2 !== w.b2) report_mismatch("tri_b2", out_tri_b2, w.b2);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_uv_sphere_vertex_generator_unit: FAIL");
      $finish;
    end
  end

  initial begin
    vertex_t typed;
    logic [7:0] sec, stk;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_stack_index  = 8'h0;
    in_sector_index = 8'h0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = 3'h0;
    pwdata          = 32'h0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, run without idling so the results can be read straight off.
    foreach (rows[n]) begin
      if (rows[n].kind == ROW_COUNTS) begin
        drain();
        write_count(REG_SECTORS, rows[n].p0);
        write_count(REG_STACKS, rows[n].p1);
      end else begin
        typed = '{x: 16'h0, y: 16'h0, z: 16'h0, tv: rows[n].tv,
                  a0: rows[n].a0, a1: rows[n].a1, a2: rows[n].a2,
                  b0: rows[n].b0, b1: rows[n].b1, b2: rows[n].b2};
        send_request(rows[n].p0, rows[n].p1, rows[n].has_tri, typed);
      end
    end

    // Random part in three idling modes; counts change between batches once idle.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 22 : (mode == 1) ? 50 : 0;
      recv_idle = (mode == 0) ? 50 : (mode == 1) ? 22 : 0;
      for (int batch = 0; batch < 4; batch++) begin
        drain();
        sec = random_count(3);
        stk = random_count(2);
        write_count(REG_SECTORS, sec);
        write_count(REG_STACKS, stk);
        for (int n = 0; n < 42; n++) begin
          send_request(random_index(stk < 2 ? 8'd2 : stk),
                       random_index(sec < 3 ? 8'd3 : sec), 1'b0, typed);
        end
      end
    end

    recv_idle = 0;
    drain();
    if (mismatches == 0) begin
      $display("tb_uv_sphere_vertex_generator_unit: PASS");
    end else begin
      $display("tb_uv_sphere_vertex_generator_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/uvs_pkg.sv
hw/rtl/uvs_div_cell.sv
hw/rtl/uvs_cordic_cell.sv
hw/rtl/uv_sphere_vertex_generator_unit.sv
tb/tb_uv_sphere_vertex_generator_unit.sv
